// ===== rtl/core/tmcl_pkg.sv =====
package tmcl_pkg;

  localparam int MIP_MAX   = 14;
  localparam int ARRAY_MAX = 4;

  localparam logic [14:0] MAXDIM_RESET = 15'd8192;
  localparam logic [18:0] ROW_SAT      = 19'h7FFFF;

  localparam logic REC_ENTRY   = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    FMT_PLAIN   = 3'd0,
    FMT_BC8     = 3'd1,
    FMT_BC16    = 3'd2,
    FMT_PACKED4 = 3'd3,
    FMT_PACKED8 = 3'd4,
    FMT_PLANAR2 = 3'd5,
    FMT_PLANAR4 = 3'd6,
    FMT_NV11    = 3'd7
  } fmt_class_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OVERRUN = 2'd1,
    STAT_EMPTY   = 2'd2
  } stat_code_t;

  typedef struct packed {
    logic [14:0] tex_width;
    logic [14:0] tex_height;
    logic [11:0] tex_depth;
    logic [3:0]  mip_levels;
    logic [2:0]  array_count;
    logic [2:0]  format_class;
    logic [7:0]  pixel_bits;
    logic [31:0] data_bytes;
  } in_word_t;

  typedef struct packed {
    logic        record_kind;
    logic [5:0]  sub_index;
    logic [31:0] byte_offset;
    logic [18:0] row_pitch;
    logic [31:0] slice_bytes;
    logic [1:0]  status;
    logic [14:0] top_width;
    logic [14:0] top_height;
    logic [11:0] top_depth;
    logic [3:0]  skipped_mips;
    logic        last_record;
  } out_word_t;

endpackage

// ===== rtl/core/texture_mip_chain_layout.sv =====
// mip levels walked = mips times array slices, fewer on overrun; one entry word per kept level
// one item at a time: start is taken only in idle, and the walk uses the shared 36x16 multiplier
// used three times per level (row, slice, offset advance); busy high meanwhile
// reset: rst_n synchronous active low, max_dimension back to 8192, walk aborted
// results are strobed on out_valid for one cycle; the receiver cannot stall
module texture_mip_chain_layout (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tmcl_pkg::in_word_t  in_data,
  output logic                out_valid,
  output tmcl_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [14:0]         cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_MUL,
    S_ROW_FIN,
    S_SL_MUL,
    S_SL_FIN,
    S_ADV_MUL,
    S_CHECK,
    S_DONE
  } state_t;

  state_t              state_r;
  logic                busy_r;
  logic                out_valid_r;
  tmcl_pkg::out_word_t out_r;
  tmcl_pkg::out_word_t out_nxt;
  logic [14:0]         max_dim_r;

  logic [14:0] w_r, h_r, top_w0_r, top_h0_r;
  logic [11:0] d_r, top_d0_r;
  logic [3:0]  mips_r, lvl_r, skipped_r;
  logic [2:0]  arrays_r, slc_r;
  logic [2:0]  cls_r;
  logic [7:0]  bpp_r;
  logic [31:0] limit_r, offset_r;
  logic [5:0]  kept_r;
  logic [14:0] tw_r, th_r;
  logic [11:0] td_r;
  logic        fail_r;
  logic [51:0] prod_r;
  logic [19:0] row_r;
  logic [35:0] slice_r;

  logic [35:0] mul_a;
  logic [15:0] mul_b;
  logic [51:0] prod_nxt;
  logic [15:0] w_quad, w_half, h_quad;
  logic [23:0] plain_row;
  logic [19:0] row_nxt;
  logic [35:0] slice_nxt;
  logic [48:0] sum_nxt;
  logic        over, keep;
  logic [3:0]  mips_sat;
  logic [2:0]  arrays_sat;
  tmcl_pkg::fmt_class_t cls;

  assign cls    = tmcl_pkg::fmt_class_t'(cls_r);
  assign w_quad = ({1'b0, w_r} + 16'd3) >> 2;
  assign w_half = ({1'b0, w_r} + 16'd1) >> 1;
  assign h_quad = ({1'b0, h_r} + 16'd3) >> 2;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_ROW_MUL: begin
        case (cls)
          tmcl_pkg::FMT_BC8: begin
            mul_a = 36'(w_quad);
            mul_b = 16'd8;
          end
          tmcl_pkg::FMT_BC16: begin
            mul_a = 36'(w_quad);
            mul_b = 16'd16;
          end
          tmcl_pkg::FMT_PACKED4: begin
            mul_a = 36'(w_half);
            mul_b = 16'd4;
          end
          tmcl_pkg::FMT_PACKED8: begin
            mul_a = 36'(w_half);
            mul_b = 16'd8;
          end
          tmcl_pkg::FMT_PLANAR2: begin
            mul_a = 36'(w_half);
            mul_b = 16'd2;
          end
          tmcl_pkg::FMT_PLANAR4: begin
            mul_a = 36'(w_half);
            mul_b = 16'd4;
          end
          tmcl_pkg::FMT_NV11: begin
            mul_a = 36'(w_quad);
            mul_b = 16'd4;
          end
          default: begin
            mul_a = 36'(w_r);
            mul_b = 16'(bpp_r);
          end
        endcase
      end
      S_SL_MUL: begin
        mul_a = 36'(row_r);
        case (cls)
          tmcl_pkg::FMT_BC8, tmcl_pkg::FMT_BC16: mul_b = h_quad;
          tmcl_pkg::FMT_NV11:                    mul_b = {h_r, 1'b0};
          default:                               mul_b = 16'(h_r);
        endcase
      end
      S_ADV_MUL: begin
        mul_a = slice_r;
        mul_b = 16'(d_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt  = {16'd0, mul_a} * {36'd0, mul_b};
  assign plain_row = ({1'b0, prod_r[22:0]} + 24'd7) >> 3;
  assign row_nxt   = (cls == tmcl_pkg::FMT_PLAIN) ? plain_row[19:0] : prod_r[19:0];
  assign slice_nxt = (cls == tmcl_pkg::FMT_PLANAR2 || cls == tmcl_pkg::FMT_PLANAR4)
                     ? prod_r[35:0] + ((prod_r[35:0] + 36'd1) >> 1)
                     : prod_r[35:0];
  assign sum_nxt   = {17'd0, offset_r} + {1'b0, prod_r[47:0]};
  assign over      = sum_nxt > {17'd0, limit_r};
  assign keep      = (mips_r <= 4'd1) || (max_dim_r == 15'd0) ||
                     ((w_r <= max_dim_r) && (h_r <= max_dim_r) &&
                      ({3'd0, d_r} <= max_dim_r));

  assign mips_sat   = (in_data.mip_levels > 4'(tmcl_pkg::MIP_MAX))
                      ? 4'(tmcl_pkg::MIP_MAX) : in_data.mip_levels;
  assign arrays_sat = (in_data.array_count > 3'(tmcl_pkg::ARRAY_MAX))
                      ? 3'(tmcl_pkg::ARRAY_MAX) : in_data.array_count;

  always_comb begin
    out_nxt = '0;
    if (state_r == S_CHECK && keep) begin
      out_nxt.record_kind = tmcl_pkg::REC_ENTRY;
      out_nxt.sub_index   = kept_r;
      out_nxt.byte_offset = offset_r;
      out_nxt.row_pitch   = (row_r > 20'(tmcl_pkg::ROW_SAT))
                            ? tmcl_pkg::ROW_SAT : row_r[18:0];
      out_nxt.slice_bytes = (|slice_r[35:32]) ? 32'hFFFF_FFFF : slice_r[31:0];
    end else if (state_r == S_DONE) begin
      out_nxt.record_kind  = tmcl_pkg::REC_SUMMARY;
      out_nxt.status       = fail_r ? tmcl_pkg::STAT_OVERRUN :
                             (kept_r == 6'd0) ? tmcl_pkg::STAT_EMPTY :
                             tmcl_pkg::STAT_OK;
      out_nxt.top_width    = tw_r;
      out_nxt.top_height   = th_r;
      out_nxt.top_depth    = td_r;
      out_nxt.skipped_mips = skipped_r;
      out_nxt.last_record  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r <= tmcl_pkg::MAXDIM_RESET;
    end else if (cfg_we) begin
      max_dim_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      out_valid_r <= (state_r == S_CHECK && keep) || (state_r == S_DONE);
      out_r       <= out_nxt;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            busy_r    <= 1'b1;
            w_r       <= in_data.tex_width;
            h_r       <= in_data.tex_height;
            d_r       <= in_data.tex_depth;
            top_w0_r  <= in_data.tex_width;
            top_h0_r  <= in_data.tex_height;
            top_d0_r  <= in_data.tex_depth;
            mips_r    <= mips_sat;
            arrays_r  <= arrays_sat;
            cls_r     <= in_data.format_class;
            bpp_r     <= in_data.pixel_bits;
            limit_r   <= in_data.data_bytes;
            lvl_r     <= '0;
            slc_r     <= '0;
            offset_r  <= '0;
            kept_r    <= '0;
            skipped_r <= '0;
            tw_r      <= '0;
            th_r      <= '0;
            td_r      <= '0;
            fail_r    <= 1'b0;
            state_r   <= (mips_sat == 4'd0 || arrays_sat == 3'd0) ? S_DONE : S_ROW_MUL;
          end
        end
        S_ROW_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= S_ROW_FIN;
        end
        S_ROW_FIN: begin
          row_r   <= row_nxt;
          state_r <= S_SL_MUL;
        end
        S_SL_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= S_SL_FIN;
        end
        S_SL_FIN: begin
          slice_r <= slice_nxt;
          state_r <= S_ADV_MUL;
        end
        S_ADV_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (keep) begin
            kept_r <= kept_r + 6'd1;
            if (tw_r == 15'd0) begin
              tw_r <= w_r;
              th_r <= h_r;
              td_r <= d_r;
            end
          end else if (slc_r == 3'd0) begin
            skipped_r <= skipped_r + 4'd1;
          end
          if (over) begin
            fail_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            offset_r <= sum_nxt[31:0];
            if (lvl_r + 4'd1 == mips_r) begin
              if (slc_r + 3'd1 == arrays_r) begin
                state_r <= S_DONE;
              end else begin
                slc_r   <= slc_r + 3'd1;
                lvl_r   <= '0;
                w_r     <= top_w0_r;
                h_r     <= top_h0_r;
                d_r     <= top_d0_r;
                state_r <= S_ROW_MUL;
              end
            end else begin
              lvl_r   <= lvl_r + 4'd1;
              w_r     <= (w_r[14:1] == 14'd0) ? 15'd1 : {1'b0, w_r[14:1]};
              h_r     <= (h_r[14:1] == 14'd0) ? 15'd1 : {1'b0, h_r[14:1]};
              d_r     <= (d_r[11:1] == 11'd0) ? 12'd1 : {1'b0, d_r[11:1]};
              state_r <= S_ROW_MUL;
            end
          end
        end
        S_DONE: begin
          busy_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
